@@ hw/rtl/hbt_pkg.sv @@
// ----------------------------------------------------------------------------
// hbt_pkg
// Shared types, widths and register indexes of the hard branch table.
// ----------------------------------------------------------------------------
`default_nettype none

package hbt_pkg;

	localparam int PC_W       = 48;
	localparam int CNT_W      = 8;
	localparam int PERIOD_W   = 20;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_COUNTER_MAX    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HARD_THRESHOLD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DECAY_PERIOD   = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [CNT_W-1:0]    COUNTER_MAX_RST    = 8'd3;
	localparam logic [CNT_W-1:0]    HARD_THRESHOLD_RST = 8'd1;
	localparam logic [PERIOD_W-1:0] DECAY_PERIOD_RST   = 20'd50000;

	// Request modes.
	localparam logic MODE_UPDATE = 1'b0;
	localparam logic MODE_LOOKUP = 1'b1;

	typedef struct packed {
		logic            mode;
		logic [PC_W-1:0] pc;
		logic            mispredict;
		logic            misfetch;
	} request_t;

	typedef struct packed {
		logic             hit;
		logic [CNT_W-1:0] count_value;
		logic             hard;
		logic             skipped;
	} result_t;

	typedef struct packed {
		logic write;  // entry must be written back
		logic decay;  // counted update reached the decay period
	} alu_status_t;

	function automatic logic [CNT_W-1:0] sat_dec(input logic [CNT_W-1:0] v);
		return (v == '0) ? v : v - 1'b1;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/hbt_ram.sv @@
// ----------------------------------------------------------------------------
// hbt_ram
// Single write port, single read port table memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hbt_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 46
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ hw/rtl/hbt_alu.sv @@
// ----------------------------------------------------------------------------
// hbt_alu
// Shared entry unit: tag compare, saturating counter update and decrement.
// Serves both request execution and the decay sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module hbt_alu
	import hbt_pkg::*;
#(
	parameter int TAG_W = 38
) (
	input  wire logic             sweep,
	input  wire logic             mode,
	input  wire logic             bump,
	input  wire logic [TAG_W-1:0] entry_tag,
	input  wire logic [CNT_W-1:0] entry_count,
	input  wire logic [TAG_W-1:0] req_tag,
	input  wire logic [CNT_W-1:0] counter_max,
	input  wire logic [CNT_W-1:0] hard_threshold,
	input  wire logic             period_hit,
	output logic      [TAG_W-1:0] new_tag,
	output logic      [CNT_W-1:0] new_count,
	output alu_status_t           status,
	output result_t               result
);

	logic             match;
	logic [CNT_W-1:0] bumped;
	logic [CNT_W-1:0] shown;

	assign match = (entry_tag == req_tag);

	always_comb begin
		bumped = entry_count;
		if (bump) begin
			bumped = (entry_count >= counter_max) ? counter_max : entry_count + 1'b1;
		end
		shown = period_hit ? sat_dec(bumped) : bumped;
	end

	always_comb begin
		new_tag   = entry_tag;
		new_count = entry_count;
		status    = '0;
		result    = '0;
		if (sweep) begin
			new_count    = sat_dec(entry_count);
			status.write = 1'b1;
		end else if (mode == MODE_LOOKUP) begin
			result.hit         = match;
			result.count_value = match ? entry_count : '0;
			result.hard        = match && (entry_count > hard_threshold);
		end else if (!match && (entry_count != '0)) begin
			// Entry is owned by another branch that still has history.
			result.skipped = 1'b1;
		end else begin
			// The stored count stays undecayed; the sweep that follows decays it.
			new_tag            = req_tag;
			new_count          = bumped;
			status.write       = 1'b1;
			status.decay       = period_hit;
			result.hit         = 1'b1;
			result.count_value = shown;
			result.hard        = shown > hard_threshold;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/hard_branch_table_core.sv @@
// ----------------------------------------------------------------------------
// hard_branch_table_core
// Tagged, direct-mapped table of saturating mispredict counters.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Each request gives
// one result, shown for one cycle with done high after the entry is read and
// the result registered; the receiver cannot stall, so it must capture the
// result on that cycle. Requests run one at a time: the entry is read, then
// written back where the request changes it, and a new request is taken only
// once busy is low again. After reset the table is cleared one entry per
// cycle, busy staying high until every entry is cleared. When an update
// completes a decay period, its result still appears on time, but busy then
// stays high while every counter is decremented in a sweep. TABLE_ENTRIES
// must be a power of two. Configuration writes are taken at any time but
// should only be made while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module hard_branch_table_core
	import hbt_pkg::*;
#(
	parameter int TABLE_ENTRIES = 1024,
	parameter int PC_BITS       = 48
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire request_t              request,
	output logic                       done,
	output result_t                    result,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int IDX_W   = $clog2(TABLE_ENTRIES);
	localparam int TAG_W   = (PC_BITS > IDX_W) ? PC_BITS - IDX_W : 1;
	localparam int ENTRY_W = TAG_W + CNT_W;
	localparam int SW_W    = IDX_W + 1;

	localparam logic [1:0] S_CLEAR = 2'd0;
	localparam logic [1:0] S_IDLE  = 2'd1;
	localparam logic [1:0] S_EXEC  = 2'd2;
	localparam logic [1:0] S_SWEEP = 2'd3;

	logic [1:0]          state_q;
	logic [SW_W-1:0]     sw_q;
	logic [CNT_W-1:0]    counter_max_q;
	logic [CNT_W-1:0]    hard_threshold_q;
	logic [PERIOD_W-1:0] decay_period_q;
	logic [PERIOD_W-1:0] updates_q;
	logic                mode_q;
	logic                bump_q;
	logic [IDX_W-1:0]    idx_q;
	logic [TAG_W-1:0]    tag_q;
	logic                done_q;
	result_t             result_q;

	logic [63:0]         pc64;
	logic [PC_BITS-1:0]  pcm;
	logic [IDX_W-1:0]    req_idx;
	logic [TAG_W-1:0]    req_tag;
	logic [PERIOD_W-1:0] updates_next;
	logic                period_hit;

	logic                mem_we;
	logic [IDX_W-1:0]    mem_waddr;
	logic [ENTRY_W-1:0]  mem_wdata;
	logic [IDX_W-1:0]    mem_raddr;
	logic [ENTRY_W-1:0]  mem_rdata;

	logic [TAG_W-1:0]    alu_tag;
	logic [CNT_W-1:0]    alu_count;
	alu_status_t         alu_status;
	result_t             alu_result;

	logic                sweep_active;
	logic [SW_W-1:0]     sw_prev;

	assign pc64    = {{(64 - PC_W){1'b0}}, request.pc};
	assign pcm     = pc64[PC_BITS-1:0];
	assign req_idx = pcm[IDX_W-1:0];
	assign req_tag = TAG_W'(pcm >> IDX_W);

	assign updates_next = updates_q + 1'b1;
	assign period_hit   = (updates_next >= decay_period_q);

	assign sweep_active = (state_q == S_SWEEP);
	assign sw_prev      = sw_q - 1'b1;

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

	hbt_ram #(
		.DEPTH (TABLE_ENTRIES),
		.WIDTH (ENTRY_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	hbt_alu #(
		.TAG_W (TAG_W)
	) u_alu (
		.sweep          (sweep_active),
		.mode           (mode_q),
		.bump           (bump_q),
		.entry_tag      (mem_rdata[ENTRY_W-1:CNT_W]),
		.entry_count    (mem_rdata[CNT_W-1:0]),
		.req_tag        (tag_q),
		.counter_max    (counter_max_q),
		.hard_threshold (hard_threshold_q),
		.period_hit     (period_hit),
		.new_tag        (alu_tag),
		.new_count      (alu_count),
		.status         (alu_status),
		.result         (alu_result)
	);

	// Memory port steering. During the sweep the write trails the read by one
	// entry, so read and write never meet at the same address.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = {alu_tag, alu_count};
		mem_raddr = req_idx;
		case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = sw_q[IDX_W-1:0];
				mem_wdata = '0;
			end
			S_EXEC: begin
				mem_we = alu_status.write;
			end
			S_SWEEP: begin
				mem_we    = (sw_q != '0);
				mem_waddr = sw_prev[IDX_W-1:0];
				mem_raddr = sw_q[IDX_W-1:0];
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			sw_q      <= '0;
			updates_q <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					sw_q <= sw_q + 1'b1;
					if (sw_q == SW_W'(TABLE_ENTRIES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
					if (mode_q == MODE_UPDATE && !alu_result.skipped) begin
						updates_q <= alu_status.decay ? '0 : updates_next;
					end
					if (alu_status.decay) begin
						sw_q    <= '0;
						state_q <= S_SWEEP;
					end
				end
				S_SWEEP: begin
					sw_q <= sw_q + 1'b1;
					if (sw_q == SW_W'(TABLE_ENTRIES)) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			mode_q <= request.mode;
			bump_q <= request.mispredict | request.misfetch;
			idx_q  <= req_idx;
			tag_q  <= req_tag;
		end
		if (state_q == S_EXEC) begin
			result_q <= alu_result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_max_q    <= COUNTER_MAX_RST;
			hard_threshold_q <= HARD_THRESHOLD_RST;
			decay_period_q   <= DECAY_PERIOD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_COUNTER_MAX:    counter_max_q    <= cfg_data[CNT_W-1:0];
				CFG_HARD_THRESHOLD: hard_threshold_q <= cfg_data[CNT_W-1:0];
				CFG_DECAY_PERIOD:   decay_period_q   <= cfg_data[PERIOD_W-1:0];
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire
